[hdl/gray_histogram_stretch_unit_macros.svh]
// Assertion macros shared by the gray histogram stretch modules.
`ifndef GRAY_HISTOGRAM_STRETCH_UNIT_MACROS_SVH
`define GRAY_HISTOGRAM_STRETCH_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define GHS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gray_histogram_stretch_unit: assertion failed");

// Next-cycle implication, disabled while in reset.
`define GHS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gray_histogram_stretch_unit: assertion failed");

`endif

[hdl/ghs_pkg.sv]
// Types, constants and handshake structs of the gray histogram stretch unit.
package ghs_pkg;

  localparam int PixelField = 8;
  localparam int PixelBits  = 8;
  localparam int NumBits    = 2 * PixelBits;
  localparam int DivSteps   = PixelBits;
  localparam int CntBits    = (DivSteps > 1) ? $clog2(DivSteps) : 1;

  localparam logic [PixelBits-1:0] LevelFull = {PixelBits{1'b1}};

  typedef enum logic {
    FUNC_MEASURE = 1'b0,
    FUNC_APPLY   = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_LOAD
  } ctrl_state_t;

  typedef struct packed {
    logic take_measure;
    logic take_apply;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic quick;
    logic out_free;
  } dp_status_t;

endpackage

[hdl/gray_histogram_stretch_unit.sv]
// Min-max contrast stretch of gray pixels: top level.
//
// Input stream: s_axis_tdata carries the pixel; s_axis_tuser carries the item
// kind (measure or apply) and the frame start flag. A measure transaction
// folds the pixel into the running min/max (frame start, or the first pixel
// after reset, restarts both) and yields nothing. An apply transaction yields
// one output transaction: the pixel mapped so min goes to 0 and max to 255,
// rounded to nearest with ties to even, with flat_range set and level 0 when
// the range is empty or flat.
// Sequence: a measure item is taken in the idle state alone. An apply item whose
// answer is known from the compares alone (flat range, pixel at or below min, at
// or above max) goes straight to the load step; otherwise it first runs the 8 steps
// of the restoring divider, one quotient bit per cycle. The result shows on the
// output the cycle after the load.
// The output register frees the input side: new items are taken while a
// result waits; a stalled receiver holds a finished result in the load step
// until the register drains. Reset (rst, synchronous) empties the output and
// sets min to 255, max to 0, nothing measured.
module gray_histogram_stretch_unit
  import ghs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
  input  logic [1:0]  s_axis_tuser,   // [0] func, [1] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] stretched, [15:8] range_low, [23:16] range_high
  output logic        m_axis_tuser    // [0] flat_range
);

  dp_cmd_t               cmd;
  dp_status_t            status;
  logic [PixelField-1:0] out_stretched;
  logic [PixelField-1:0] out_low;
  logic [PixelField-1:0] out_high;

  ghs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_apply (s_axis_tuser[0] == FUNC_APPLY),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ghs_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .pixel         (s_axis_tdata),
    .frame_start   (s_axis_tuser[1]),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_stretched (out_stretched),
    .out_flat      (m_axis_tuser),
    .out_low       (out_low),
    .out_high      (out_high)
  );

  assign m_axis_tdata = {out_high, out_low, out_stretched};

endmodule

[hdl/ghs_div.sv]
// Restoring divider, one quotient bit per step, rounding to nearest with ties to even.
module ghs_div
  import ghs_pkg::*;
(
  input  logic                 clk,
  input  logic                 init,
  input  logic                 step,
  input  logic [NumBits-1:0]   num,
  input  logic [PixelBits-1:0] den,
  output logic [PixelBits-1:0] result
);

  logic [PixelBits-1:0] rem;
  logic [PixelBits-1:0] nq;
  logic [PixelBits-1:0] dvs;
  logic [PixelBits:0]   rem_sh;
  logic                 ge;
  logic [PixelBits:0]   two_r;
  logic                 round_up;

  // Numerator is below den << PixelBits, so the upper half starts below den.
  assign rem_sh = {rem, nq[PixelBits-1]};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (init) begin
      rem <= num[NumBits-1:PixelBits];
      nq  <= num[PixelBits-1:0];
      dvs <= den;
    end else if (step) begin
      rem <= ge ? PixelBits'(rem_sh - {1'b0, dvs}) : rem_sh[PixelBits-1:0];
      nq  <= (nq << 1) | PixelBits'(ge);
    end
  end

  assign two_r    = {rem, 1'b0};
  assign round_up = (two_r > {1'b0, dvs}) || ((two_r == {1'b0, dvs}) && nq[0]);
  assign result   = nq + PixelBits'(round_up);

endmodule

[hdl/ghs_datapath.sv]
// Min/max tracking, operand capture, divider and output register.
module ghs_datapath
  import ghs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  input  logic [PixelField-1:0] pixel,
  input  logic                  frame_start,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PixelField-1:0] out_stretched,
  output logic                  out_flat,
  output logic [PixelField-1:0] out_low,
  output logic [PixelField-1:0] out_high
);

  logic [PixelBits-1:0] level_min;
  logic [PixelBits-1:0] level_max;
  logic                 seen_any;
  logic [PixelBits-1:0] app_lo;
  logic [PixelBits-1:0] app_hi;
  logic                 app_flat;
  logic                 app_quick;
  logic [PixelBits-1:0] app_quick_val;

  logic [PixelBits-1:0] p_in;
  logic                 flat_now;
  logic                 low_now;
  logic                 high_now;
  logic [PixelBits-1:0] diff;
  logic [NumBits-1:0]   num;
  logic [PixelBits-1:0] div_result;

  assign p_in     = PixelBits'(pixel);
  assign flat_now = !seen_any || (level_max <= level_min);
  assign low_now  = p_in <= level_min;
  assign high_now = p_in >= level_max;

  // (p - min) * full scale as a shift and subtract
  assign diff = p_in - level_min;
  assign num  = {diff, {PixelBits{1'b0}}} - NumBits'(diff);

  assign status.quick    = flat_now || low_now || high_now;
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_min <= LevelFull;
      level_max <= '0;
      seen_any  <= 1'b0;
    end else if (cmd.take_measure) begin
      if (frame_start || !seen_any) begin
        level_min <= p_in;
        level_max <= p_in;
        seen_any  <= 1'b1;
      end else begin
        if (p_in < level_min) level_min <= p_in;
        if (p_in > level_max) level_max <= p_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_apply) begin
      app_lo        <= level_min;
      app_hi        <= level_max;
      app_flat      <= flat_now;
      app_quick     <= flat_now || low_now || high_now;
      app_quick_val <= (flat_now || low_now) ? '0 : LevelFull;
    end
  end

  ghs_div u_div (
    .clk    (clk),
    .init   (cmd.take_apply),
    .step   (cmd.div_step),
    .num    (num),
    .den    (level_max - level_min),
    .result (div_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_stretched <= PixelField'(app_quick ? app_quick_val : div_result);
      out_flat      <= app_flat;
      out_low       <= PixelField'(app_lo);
      out_high      <= PixelField'(app_hi);
    end
  end

  `include "gray_histogram_stretch_unit_macros.svh"

  `GHS_ASSERT_NOW(a_minmax_order, clk, rst, seen_any, level_min <= level_max)
  `GHS_ASSERT_NOW(a_flat_zero, clk, rst, out_valid && out_flat, out_stretched == '0)
  `GHS_ASSERT_NOW(a_range_open, clk, rst, out_valid && !out_flat, out_low < out_high)

endmodule

[hdl/ghs_ctrl.sv]
// Sequencer: accepts items, steps the divider, loads the output register.
module ghs_ctrl
  import ghs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_apply,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t        state;
  ctrl_state_t        state_next;
  logic [CntBits-1:0] step_cnt;
  logic               last_step;

  assign last_step = step_cnt == CntBits'(DivSteps - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else if (state != ST_DIVIDE) begin
      step_cnt <= '0;
    end else begin
      step_cnt <= step_cnt + CntBits'(1);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_apply) begin
          state_next = status.quick ? ST_LOAD : ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (last_step) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = 1'b0;
    cmd.take_measure = 1'b0;
    cmd.take_apply   = 1'b0;
    cmd.div_step     = 1'b0;
    cmd.load_out     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready         = 1'b1;
        cmd.take_measure = in_valid && !in_apply;
        cmd.take_apply   = in_valid && in_apply;
      end
      ST_DIVIDE: cmd.div_step = 1'b1;
      ST_LOAD:   cmd.load_out = status.out_free;
      default: ;
    endcase
  end

  `include "gray_histogram_stretch_unit_macros.svh"

  `GHS_ASSERT_NOW(a_no_take_busy, clk, rst, state != ST_IDLE,
                  !cmd.take_measure && !cmd.take_apply)
  `GHS_ASSERT_NEXT(a_slow_divides, clk, rst, cmd.take_apply && !status.quick,
                   state == ST_DIVIDE && step_cnt == '0)
  `GHS_ASSERT_NEXT(a_last_loads, clk, rst, state == ST_DIVIDE && last_step,
                   state == ST_LOAD)

endmodule

[sim/tb.sv]
// Self-checking testbench for the gray histogram stretch unit.
module tb;
  import ghs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DirRows    = 23;
  localparam int RandItems  = 1100;
  localparam int IdleLimit  = 1000;
  localparam int DrainWait  = 30;

  typedef struct packed {
    logic [7:0] stretched;
    logic       flat;
    logic [7:0] lo;
    logic [7:0] hi;
  } stretch_res_t;

  typedef struct {
    func_t        f;
    logic [7:0]   pix;
    logic         fs;
    logic         typed;
    stretch_res_t want;
  } stim_row_t;

  localparam stretch_res_t NO_RES = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;     // [7:0] pixel
  logic [1:0]  s_axis_tuser = '0;     // [0] func, [1] frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;          // [7:0] stretched, [15:8] range_low, [23:16] range_high
  logic        m_axis_tuser;          // [0] flat_range

  gray_histogram_stretch_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // Predictor state: running range of the measured pixels.
  logic [7:0] held_min  = 8'hFF;
  logic [7:0] held_max  = 8'h00;
  logic       held_seen = 1'b0;

  stretch_res_t stretch_q[$];

  int  n_measure  = 0;
  int  n_apply    = 0;
  int  n_checked  = 0;
  int  n_flat     = 0;
  int  n_clipped  = 0;
  int  n_errors   = 0;
  int  idle_cycles = 0;
  bit  in_burst   = 1'b0;
  bit  out_burst  = 1'b0;

  stim_row_t dir_rows [DirRows] = '{
    '{FUNC_APPLY,   8'd0,   1'b0, 1'b1, '{8'd0,   1'b1, 8'd255, 8'd0}},
    '{FUNC_APPLY,   8'd255, 1'b1, 1'b1, '{8'd0,   1'b1, 8'd255, 8'd0}},
    '{FUNC_MEASURE, 8'd100, 1'b0, 1'b0, NO_RES},
    '{FUNC_APPLY,   8'd100, 1'b0, 1'b1, '{8'd0,   1'b1, 8'd100, 8'd100}},
    '{FUNC_MEASURE, 8'd0,   1'b1, 1'b0, NO_RES},
    '{FUNC_MEASURE, 8'd255, 1'b0, 1'b0, NO_RES},
    '{FUNC_APPLY,   8'd0,   1'b0, 1'b1, '{8'd0,   1'b0, 8'd0,   8'd255}},
    '{FUNC_APPLY,   8'd255, 1'b0, 1'b1, '{8'd255, 1'b0, 8'd0,   8'd255}},
    '{FUNC_APPLY,   8'd128, 1'b0, 1'b0, NO_RES},
    '{FUNC_MEASURE, 8'd50,  1'b1, 1'b0, NO_RES},
    '{FUNC_MEASURE, 8'd60,  1'b0, 1'b0, NO_RES},
    '{FUNC_APPLY,   8'd55,  1'b0, 1'b0, NO_RES},
    '{FUNC_APPLY,   8'd53,  1'b0, 1'b0, NO_RES},
    '{FUNC_APPLY,   8'd45,  1'b0, 1'b1, '{8'd0,   1'b0, 8'd50,  8'd60}},
    '{FUNC_APPLY,   8'd70,  1'b0, 1'b1, '{8'd255, 1'b0, 8'd50,  8'd60}},
    '{FUNC_APPLY,   8'd60,  1'b1, 1'b1, '{8'd255, 1'b0, 8'd50,  8'd60}},
    '{FUNC_MEASURE, 8'd57,  1'b0, 1'b0, NO_RES},
    '{FUNC_APPLY,   8'd51,  1'b0, 1'b0, NO_RES},
    '{FUNC_MEASURE, 8'd200, 1'b1, 1'b0, NO_RES},
    '{FUNC_APPLY,   8'd200, 1'b0, 1'b1, '{8'd0,   1'b1, 8'd200, 8'd200}},
    '{FUNC_MEASURE, 8'd201, 1'b0, 1'b0, NO_RES},
    '{FUNC_APPLY,   8'd201, 1'b0, 1'b1, '{8'd255, 1'b0, 8'd200, 8'd201}},
    '{FUNC_APPLY,   8'd170, 1'b0, 1'b1, '{8'd0,   1'b0, 8'd200, 8'd201}}
  };

  // Mostly short stretches, now and then a long one.
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Round (p - min) * 255 / (max - min) to nearest, ties to even, clip to 255.
  function automatic stretch_res_t stretch_predict(logic [7:0] pix);
    stretch_res_t res;
    int unsigned  num, den, q, r;
    res.lo   = held_min;
    res.hi   = held_max;
    res.flat = !held_seen || (held_max <= held_min);
    res.stretched = 8'd0;
    if (!res.flat && pix > held_min) begin
      den = 32'(held_max) - 32'(held_min);
      num = (32'(pix) - 32'(held_min)) * 255;
      q = num / den;
      r = num % den;
      if (2 * r > den || (2 * r == den && q[0])) q++;
      if (q > 255) q = 255;
      res.stretched = q[7:0];
    end
    return res;
  endfunction

  task automatic fold_level(logic [7:0] pix, logic fs);
    if (fs || !held_seen) begin
      held_min  = pix;
      held_max  = pix;
      held_seen = 1'b1;
    end else begin
      if (pix < held_min) held_min = pix;
      if (pix > held_max) held_max = pix;
    end
  endtask

  // Drive one item, wait for its transaction, then record what it should yield.
  task automatic send_pixel(func_t f, logic [7:0] pix, logic fs, logic typed,
                            stretch_res_t want);
    int gap;
    stretch_res_t res;
    gap = in_burst ? 0 : (($urandom_range(0, 99) < 55) ? 0 : pick_len());
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= {fs, f};
    do @(posedge clk); while (!s_axis_tready);
    if (f == FUNC_MEASURE) begin
      fold_level(pix, fs);
      n_measure++;
    end else begin
      res = typed ? want : stretch_predict(pix);
      stretch_q.push_back(res);
      n_apply++;
    end
  endtask

  task automatic check_result();
    stretch_res_t want, got;
    got.stretched = m_axis_tdata[7:0];
    got.lo        = m_axis_tdata[15:8];
    got.hi        = m_axis_tdata[23:16];
    got.flat      = m_axis_tuser;
    if (stretch_q.size() == 0) begin
      $display("%0t: unexpected result, actual %h", $realtime, got);
      n_errors++;
    end else begin
      want = stretch_q.pop_front();
      n_checked++;
      if (want.flat) n_flat++;
      if (!want.flat && (want.stretched == 8'd0 || want.stretched == 8'd255)) n_clipped++;
      if (got.stretched !== want.stretched) begin
        $display("%0t: stretched expected %0d actual %0d", $realtime,
                 want.stretched, got.stretched);
        n_errors++;
      end
      if (got.flat !== want.flat) begin
        $display("%0t: flat_range expected %0b actual %0b", $realtime, want.flat, got.flat);
        n_errors++;
      end
      if (got.lo !== want.lo) begin
        $display("%0t: range_low expected %0d actual %0d", $realtime, want.lo, got.lo);
        n_errors++;
      end
      if (got.hi !== want.hi) begin
        $display("%0t: range_high expected %0d actual %0d", $realtime, want.hi, got.hi);
        n_errors++;
      end
    end
  endtask

  // Receiver: check each output transaction, then pick the next ready level.
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) check_result();
    if ($urandom_range(0, 199) == 0) out_burst = !out_burst;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if (!out_burst && $urandom_range(0, 99) < 30) stall_left = pick_len();
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no transaction for %0d cycles", $realtime, IdleLimit);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int n_sent;
    int n_meas, n_app, spread;
    logic [7:0] lo, hi_lim;
    bit keep_range;
    logic fs;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_pixel(dir_rows[i].f, dir_rows[i].pix, dir_rows[i].fs, dir_rows[i].typed,
                 dir_rows[i].want);

    n_sent = 0;
    while (n_sent < RandItems) begin
      if ($urandom_range(0, 5) == 0) in_burst = !in_burst;
      if ($urandom_range(0, 9) == 0) begin
        // Stray item outside any frame structure.
        send_pixel(func_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 1'b0, NO_RES);
        n_sent++;
      end else begin
        lo = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
          0: spread = 0;
          1: spread = $urandom_range(1, 3);
          2: spread = $urandom_range(4, 40);
          default: spread = 255;
        endcase
        hi_lim = (int'(lo) + spread > 255) ? 8'd255 : 8'(int'(lo) + spread);
        keep_range = ($urandom_range(0, 9) == 0);
        n_meas = $urandom_range(1, 12);
        n_app  = $urandom_range(1, 16);
        for (int k = 0; k < n_meas; k++) begin
          fs = (k == 0) ? !keep_range : ($urandom_range(0, 19) == 0);
          send_pixel(FUNC_MEASURE, 8'($urandom_range(lo, hi_lim)), fs, 1'b0, NO_RES);
        end
        for (int k = 0; k < n_app; k++) begin
          send_pixel(FUNC_APPLY,
                     ($urandom_range(0, 9) < 8) ? 8'($urandom_range(lo, hi_lim))
                                                : 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 1'b0, NO_RES);
        end
        n_sent += n_meas + n_app;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (stretch_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    $display("Ran %0d measure and %0d apply transactions; %0d results checked.",
             n_measure, n_apply, n_checked);
    $display("Results: %0d flat range, %0d at zero or full scale; %0d mismatches.",
             n_flat, n_clipped, n_errors);
    if (n_errors == 0 && stretch_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/ghs_pkg.sv
hdl/ghs_div.sv
hdl/ghs_datapath.sv
hdl/ghs_ctrl.sv
hdl/gray_histogram_stretch_unit.sv
sim/tb.sv
